FILE: rtl/core/scj_pkg.sv
// ----------------------------------------------------------------------------
// scj_pkg
// shared types and constants of the seeded cone jet clustering block
// ----------------------------------------------------------------------------
`default_nettype none

package scj_pkg;

   // default sizes
   localparam int NUM_PARTICLES_DEF = 16;
   localparam int NUM_JETS_OUT_DEF  = 4;
   localparam int EXTRA_JETS_DEF    = 2;

   // field widths
   localparam int PT_W    = 16;
   localparam int SUMPT_W = 15;
   localparam int COORD_W = 10;
   localparam int CNT_W   = 5;
   localparam int DIFF_W  = 11;
   localparam int DNARR_W = 7;
   localparam int DSQ_W   = 21;
   localparam int WSUM_W  = 22;
   localparam int NUM_W   = 17;
   localparam int DEN_W   = 10;
   localparam int INV_W   = 18;
   localparam int WORD_W  = PT_W + 2 * COORD_W;

   // reciprocal: 2^RECIP_SHIFT / den, zero for den up to DEN_MIN
   localparam int RECIP_SHIFT = 22;
   localparam int DEN_MIN     = 16;

   // prescale shifts
   localparam int SHIFT_HI = 5;
   localparam int SHIFT_LO = 2;

   // configuration registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int RADIUS_W   = 12;
   localparam int LIMIT_W    = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_CONE_RADIUS_SQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JET_PT_CUT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIDUCIAL_LIMIT = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd1600;
   localparam logic [SUMPT_W-1:0]  PT_CUT_RESET = 15'd40;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 9'd250;

   // one jet
   typedef struct packed {
      logic        [SUMPT_W-1:0] pt;
      logic signed [COORD_W-1:0] eta;
      logic signed [COORD_W-1:0] phi;
      logic        [CNT_W-1:0]   cnt;
   } jet_type;

endpackage

`default_nettype wire

FILE: rtl/core/seeded_cone_jet_clustering.sv
// ----------------------------------------------------------------------------
// seeded_cone_jet_clustering
// seeded cone jet finder over one event of stored particles
// ----------------------------------------------------------------------------
// Each request transaction loads one particle into the next slot of the
// particle ram. The transaction that fills the last slot starts
// clustering, and no particle is taken until the jets have gone out.
// A pass streams its live particles (NUM_PARTICLES - pass) through a three
// stage pipeline off the ram's read port and writes them back with the pt
// of the particles in the cone cleared and the last live slot emptied. It
// then prescales, starts the 23 step reciprocal divider, waits on it, does
// the centroid multiply, and ends with the keep test and the sort. The
// seed of the first pass is tracked while loading and later seeds while
// scanning. The NUM_JETS_OUT jets then leave as response transactions,
// best pt first, with jet_last on the final one. The divider and the
// particle scan of every pass take most of the time of an event.
// ----------------------------------------------------------------------------
`default_nettype none

module seeded_cone_jet_clustering #(
   parameter int NUM_PARTICLES = scj_pkg::NUM_PARTICLES_DEF,
   parameter int NUM_JETS_OUT  = scj_pkg::NUM_JETS_OUT_DEF,
   parameter int EXTRA_JETS    = scj_pkg::EXTRA_JETS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [scj_pkg::PT_W-1:0]     req_part_pt,
   input  wire logic signed [scj_pkg::COORD_W-1:0]  req_part_eta,
   input  wire logic signed [scj_pkg::COORD_W-1:0]  req_part_phi,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [scj_pkg::SUMPT_W-1:0]  rsp_jet_pt,
   output logic signed      [scj_pkg::COORD_W-1:0]  rsp_jet_eta,
   output logic signed      [scj_pkg::COORD_W-1:0]  rsp_jet_phi,
   output logic             [scj_pkg::CNT_W-1:0]    rsp_jet_count,
   output logic                                     rsp_jet_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [scj_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [scj_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int NUM_PASSES = NUM_JETS_OUT + EXTRA_JETS;
   localparam int IW = $clog2(NUM_PARTICLES);
   localparam int LW = $clog2(NUM_PARTICLES + 1);
   localparam int PW = $clog2(NUM_PASSES + 1);
   localparam int KW = (NUM_JETS_OUT > 1) ? $clog2(NUM_JETS_OUT) : 1;
   localparam int CW = scj_pkg::COORD_W;
   localparam int SPW = scj_pkg::SUMPT_W;
   localparam int WSW = scj_pkg::WSUM_W;

   typedef enum logic [2:0] {
      ST_LOAD, ST_SCAN, ST_PRESCALE, ST_DIVSTART, ST_DIVWAIT, ST_MULT,
      ST_FINISH, ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [scj_pkg::RADIUS_W-1:0] radius_ff;
   logic [SPW-1:0]               pt_cut_ff;
   logic [scj_pkg::LIMIT_W-1:0]  limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= scj_pkg::RADIUS_RESET;
         pt_cut_ff <= scj_pkg::PT_CUT_RESET;
         limit_ff  <= scj_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            scj_pkg::CSR_CONE_RADIUS_SQ: radius_ff <= csr_wdata[scj_pkg::RADIUS_W-1:0];
            scj_pkg::CSR_JET_PT_CUT:     pt_cut_ff <= csr_wdata;
            scj_pkg::CSR_FIDUCIAL_LIMIT: limit_ff  <= csr_wdata[scj_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // control
   logic          req_acc;
   logic          load_done;
   logic          last_pass;
   logic          scan_init;
   logic [IW-1:0] slot_ff;
   logic [LW-1:0] lim_ff;
   logic [LW-1:0] lim_next;
   logic [LW-1:0] start_idx;
   logic [PW-1:0] pass_ff;
   logic [KW-1:0] emit_ff;
   logic          issuing_ff;
   logic [IW-1:0] iss_ff;
   logic          issue_last;
   logic          recip_done;
   logic          scan_end;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_acc    = req_valid && req_ready;
   assign load_done  = req_acc && (slot_ff == IW'(NUM_PARTICLES - 1));
   assign last_pass  = (pass_ff == PW'(NUM_PASSES - 1));
   assign lim_next   = (lim_ff == '0) ? '0 : lim_ff - 1'b1;
   assign start_idx  = lim_next;
   assign issue_last = (LW'(iss_ff) == lim_ff - 1'b1);
   assign scan_init  = load_done || (state_ff == ST_FINISH && !last_pass);

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         slot_ff    <= '0;
         lim_ff     <= LW'(NUM_PARTICLES);
         pass_ff    <= '0;
         emit_ff    <= '0;
         issuing_ff <= 1'b0;
         iss_ff     <= '0;
      end else begin
         if (issuing_ff) begin
            iss_ff <= iss_ff + 1'b1;
            if (issue_last) begin
               issuing_ff <= 1'b0;
            end
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_acc) begin
                  slot_ff <= load_done ? '0 : slot_ff + 1'b1;
               end
               if (load_done) begin
                  state_ff   <= ST_SCAN;
                  lim_ff     <= LW'(NUM_PARTICLES);
                  pass_ff    <= '0;
                  issuing_ff <= 1'b1;
                  iss_ff     <= '0;
               end
            end
            ST_SCAN: begin
               if (scan_end) begin
                  state_ff <= ST_PRESCALE;
               end
            end
            ST_PRESCALE: state_ff <= ST_DIVSTART;
            ST_DIVSTART: state_ff <= ST_DIVWAIT;
            ST_DIVWAIT: begin
               if (recip_done) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (last_pass) begin
                  state_ff <= ST_EMIT;
                  emit_ff  <= '0;
               end else begin
                  pass_ff <= pass_ff + 1'b1;
                  lim_ff  <= lim_next;
                  iss_ff  <= '0;
                  if (lim_next == '0) begin
                     state_ff <= ST_PRESCALE;
                  end else begin
                     state_ff   <= ST_SCAN;
                     issuing_ff <= 1'b1;
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  if (emit_ff == KW'(NUM_JETS_OUT - 1)) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     emit_ff <= emit_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   // particle ram: {pt, eta, phi}
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [scj_pkg::WORD_W-1:0]  wr_data;
   logic [scj_pkg::WORD_W-1:0]  rd_data;
   logic [scj_pkg::WORD_W-1:0]  back_data;

   scj_ram #(
      .WIDTH (scj_pkg::WORD_W),
      .DEPTH (NUM_PARTICLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issuing_ff),
      .rd_addr (iss_ff),
      .rd_data (rd_data)
   );

   // seed tracking while loading
   logic [scj_pkg::PT_W-1:0] lb_pt_ff;
   logic signed [CW-1:0]     lb_eta_ff;
   logic signed [CW-1:0]     lb_phi_ff;
   logic                     lb_take;

   assign lb_take = (slot_ff == '0) || (req_part_pt > lb_pt_ff);

   always_ff @(posedge clock) begin
      if (req_acc && lb_take) begin
         lb_pt_ff  <= req_part_pt;
         lb_eta_ff <= req_part_eta;
         lb_phi_ff <= req_part_phi;
      end
   end

   // scan pipeline stage a: ram data
   logic          va_ff, la_ff;
   logic [IW-1:0] ia_ff;
   // stage b: differences
   logic                        vb_ff, lb_ff;
   logic [IW-1:0]               ib_ff;
   logic [scj_pkg::PT_W-1:0]    ptb_ff;
   logic signed [CW-1:0]        etab_ff, phib_ff;
   logic signed [scj_pkg::DIFF_W-1:0] deb_ff, dpb_ff;
   // stage c: squares and weighted offsets
   logic                        vc_ff, lc_ff;
   logic [IW-1:0]               ic_ff;
   logic [scj_pkg::PT_W-1:0]    ptc_ff;
   logic signed [CW-1:0]        etac_ff, phic_ff;
   logic [scj_pkg::DSQ_W-1:0]   dsqe_ff, dsqp_ff;
   logic [WSW-1:0]              pe_ff, pp_ff;

   logic signed [CW-1:0] seed_eta_ff, seed_phi_ff;
   logic signed [scj_pkg::PT_W-1:0] rd_pt_s;
   logic signed [CW-1:0]            rd_eta, rd_phi;
   logic signed [2*scj_pkg::DIFF_W-1:0] sq_e, sq_p;
   logic signed [scj_pkg::PT_W+scj_pkg::DNARR_W-1:0] wp_e, wp_p;

   always_comb begin
      rd_pt_s = $signed({1'b0, ptb_ff[SPW-1:0]});
      rd_eta  = rd_data[2*CW-1:CW];
      rd_phi  = rd_data[CW-1:0];
      sq_e    = deb_ff * deb_ff;
      sq_p    = dpb_ff * dpb_ff;
      wp_e    = rd_pt_s * $signed(deb_ff[scj_pkg::DNARR_W-1:0]);
      wp_p    = rd_pt_s * $signed(dpb_ff[scj_pkg::DNARR_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= issuing_ff;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff   <= iss_ff;
      la_ff   <= issue_last;
      ib_ff   <= ia_ff;
      lb_ff   <= la_ff;
      ptb_ff  <= rd_data[scj_pkg::WORD_W-1:2*CW];
      etab_ff <= rd_eta;
      phib_ff <= rd_phi;
      deb_ff  <= {rd_eta[CW-1], rd_eta} - {seed_eta_ff[CW-1], seed_eta_ff};
      dpb_ff  <= {rd_phi[CW-1], rd_phi} - {seed_phi_ff[CW-1], seed_phi_ff};
      ic_ff   <= ib_ff;
      lc_ff   <= lb_ff;
      ptc_ff  <= ptb_ff;
      etac_ff <= etab_ff;
      phic_ff <= phib_ff;
      dsqe_ff <= sq_e[scj_pkg::DSQ_W-1:0];
      dsqp_ff <= sq_p[scj_pkg::DSQ_W-1:0];
      pe_ff   <= wp_e[WSW-1:0];
      pp_ff   <= wp_p[WSW-1:0];
   end

   // stage c: cone test, sums, write back and next seed
   logic [SPW-1:0]           spt_ff;
   logic [WSW-1:0]           se_ff, sp_ff;
   logic [scj_pkg::CNT_W-1:0] cnt_ff;
   logic [scj_pkg::PT_W-1:0] nb_pt_ff;
   logic signed [CW-1:0]     nb_eta_ff, nb_phi_ff;
   logic                     in_cone;
   logic                     tail;
   logic                     below;
   logic [SPW-1:0]           mp;
   logic [scj_pkg::PT_W-1:0] new_pt;

   always_comb begin
      in_cone  = ({1'b0, dsqe_ff} + {1'b0, dsqp_ff}) < (scj_pkg::DSQ_W+1)'(radius_ff);
      mp       = in_cone ? ptc_ff[SPW-1:0] : '0;
      tail     = (LW'(ic_ff) >= start_idx);
      below    = !tail;
      new_pt   = (in_cone || tail) ? '0 : ptc_ff;
      scan_end = vc_ff && lc_ff;
      back_data = {new_pt, tail ? '0 : etac_ff, tail ? '0 : phic_ff};
      wr_en    = req_acc || vc_ff;
      wr_addr  = req_acc ? slot_ff : ic_ff;
      wr_data  = req_acc ? {req_part_pt, req_part_eta, req_part_phi} : back_data;
   end

   always_ff @(posedge clock) begin
      if (scan_init) begin
         spt_ff    <= '0;
         se_ff     <= '0;
         sp_ff     <= '0;
         cnt_ff    <= '0;
         nb_pt_ff  <= '0;
         nb_eta_ff <= '0;
         nb_phi_ff <= '0;
      end else if (vc_ff) begin
         spt_ff <= spt_ff + mp;
         se_ff  <= se_ff + (in_cone ? pe_ff : '0);
         sp_ff  <= sp_ff + (in_cone ? pp_ff : '0);
         if (mp != '0) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (below && (ic_ff == '0 || new_pt > nb_pt_ff)) begin
            nb_pt_ff  <= new_pt;
            nb_eta_ff <= etac_ff;
            nb_phi_ff <= phic_ff;
         end
      end
   end

   // seed of the current pass
   always_ff @(posedge clock) begin
      if (load_done) begin
         seed_eta_ff <= lb_take ? req_part_eta : lb_eta_ff;
         seed_phi_ff <= lb_take ? req_part_phi : lb_phi_ff;
      end else if (state_ff == ST_FINISH) begin
         seed_eta_ff <= nb_eta_ff;
         seed_phi_ff <= nb_phi_ff;
      end
   end

   // prescale of denominator and numerators
   logic [scj_pkg::DEN_W-1:0]        den_ff;
   logic signed [scj_pkg::NUM_W-1:0] ne_ff, np_ff;
   logic [2:0]                       sh;
   logic [SPW-1:0]                   den_full;
   logic signed [WSW-1:0]            ne_full, np_full;

   always_comb begin
      if (spt_ff[14:12] != '0) begin
         sh = 3'(scj_pkg::SHIFT_HI);
      end else if (spt_ff[11:10] != '0) begin
         sh = 3'(scj_pkg::SHIFT_LO);
      end else begin
         sh = '0;
      end
      den_full = spt_ff >> sh;
      ne_full  = $signed(se_ff) >>> sh;
      np_full  = $signed(sp_ff) >>> sh;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PRESCALE) begin
         den_ff <= den_full[scj_pkg::DEN_W-1:0];
         ne_ff  <= ne_full[scj_pkg::NUM_W-1:0];
         np_ff  <= np_full[scj_pkg::NUM_W-1:0];
      end
   end

   // reciprocal
   logic [scj_pkg::INV_W-1:0] inv;

   scj_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIVSTART),
      .den   (den_ff),
      .done  (recip_done),
      .quot  (inv)
   );

   // centroid offsets
   localparam int PRODW = scj_pkg::NUM_W + scj_pkg::INV_W + 1;
   logic signed [PRODW-1:0] prod_e_ff, prod_p_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MULT) begin
         prod_e_ff <= ne_ff * $signed({1'b0, inv});
         prod_p_ff <= np_ff * $signed({1'b0, inv});
      end
   end

   // centroid and keep test
   scj_pkg::jet_type      cand;
   logic signed [CW-1:0]  jet_eta, jet_phi;
   logic signed [CW:0]    lim_pos, lim_neg;
   logic                  keep;

   always_comb begin
      jet_eta = seed_eta_ff + prod_e_ff[scj_pkg::RECIP_SHIFT+CW-1:scj_pkg::RECIP_SHIFT];
      jet_phi = seed_phi_ff + prod_p_ff[scj_pkg::RECIP_SHIFT+CW-1:scj_pkg::RECIP_SHIFT];
      lim_pos = $signed({2'b00, limit_ff});
      lim_neg = -lim_pos;
      keep = (spt_ff >= pt_cut_ff)
          && ($signed({jet_eta[CW-1], jet_eta}) >= lim_neg)
          && ($signed({jet_eta[CW-1], jet_eta}) <= lim_pos)
          && ($signed({jet_phi[CW-1], jet_phi}) >= lim_neg)
          && ($signed({jet_phi[CW-1], jet_phi}) <= lim_pos);
      cand = '0;
      if (keep) begin
         cand.pt  = spt_ff;
         cand.eta = jet_eta;
         cand.phi = jet_phi;
         cand.cnt = cnt_ff;
      end
   end

   // top list and responses
   scj_pkg::jet_type out_jet;

   scj_sort #(
      .NUM_JETS_OUT (NUM_JETS_OUT),
      .KW           (KW)
   ) u_sort (
      .clock      (clock),
      .clear      (load_done),
      .cand_valid (state_ff == ST_FINISH),
      .cand       (cand),
      .rd_idx     (emit_ff),
      .rd_jet     (out_jet)
   );

   assign rsp_valid     = (state_ff == ST_EMIT);
   assign rsp_jet_pt    = out_jet.pt;
   assign rsp_jet_eta   = out_jet.eta;
   assign rsp_jet_phi   = out_jet.phi;
   assign rsp_jet_count = out_jet.cnt;
   assign rsp_jet_last  = (emit_ff == KW'(NUM_JETS_OUT - 1));

`ifndef SYNTHESIS
   a_no_load_while_emit : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("particle taken while jets pending");

   a_pass_range : assert property (@(posedge clock) disable iff (reset)
      pass_ff <= PW'(NUM_PASSES - 1)) else $error("pass count overrun");

   a_scan_in_scan : assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> state_ff == ST_SCAN) else $error("scan write back outside scan");

   a_back_to_load : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_jet_last |=> req_ready)
      else $error("no return to loading after last jet");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/scj_ram.sv
// ----------------------------------------------------------------------------
// scj_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module scj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/scj_recip.sv
// ----------------------------------------------------------------------------
// scj_recip
// restoring divider, one quotient bit a cycle, for 2^22 / den
// ----------------------------------------------------------------------------
`default_nettype none

module scj_recip (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [scj_pkg::DEN_W-1:0]       den,
   output logic                                 done,
   output logic      [scj_pkg::INV_W-1:0]       quot
);

   localparam int SW = $clog2(scj_pkg::RECIP_SHIFT + 1);

   logic                        busy_ff;
   logic                        done_ff;
   logic [SW-1:0]               step_ff;
   logic [scj_pkg::DEN_W-1:0]   rem_ff;
   logic [scj_pkg::DEN_W-1:0]   den_ff;
   logic [scj_pkg::INV_W-1:0]   q_ff;
   logic [scj_pkg::DEN_W:0]     shifted;
   logic [scj_pkg::DEN_W:0]     diff;
   logic                        ge;

   // one restoring step; the only set dividend bit is the top one
   always_comb begin
      shifted = {rem_ff, (step_ff == SW'(scj_pkg::RECIP_SHIFT))};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= SW'(scj_pkg::RECIP_SHIFT);
         rem_ff  <= '0;
         q_ff    <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         step_ff <= step_ff - 1'b1;
         rem_ff  <= ge ? diff[scj_pkg::DEN_W-1:0] : shifted[scj_pkg::DEN_W-1:0];
         q_ff    <= {q_ff[scj_pkg::INV_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = (den_ff > scj_pkg::DEN_W'(scj_pkg::DEN_MIN)) ? q_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/core/scj_sort.sv
// ----------------------------------------------------------------------------
// scj_sort
// top list of jets kept by descending pt, insertion of one candidate a pass
// ----------------------------------------------------------------------------
`default_nettype none

module scj_sort #(
   parameter int NUM_JETS_OUT = scj_pkg::NUM_JETS_OUT_DEF,
   parameter int KW           = (NUM_JETS_OUT > 1) ? $clog2(NUM_JETS_OUT) : 1
) (
   input  wire logic             clock,
   input  wire logic             clear,
   input  wire logic             cand_valid,
   input  wire scj_pkg::jet_type cand,
   input  wire logic [KW-1:0]    rd_idx,
   output scj_pkg::jet_type      rd_jet
);

   scj_pkg::jet_type top_ff [NUM_JETS_OUT];
   scj_pkg::jet_type top_in [NUM_JETS_OUT];

   // every slot decides from the old list at once
   always_comb begin
      for (int o = 0; o < NUM_JETS_OUT; o++) begin
         top_in[o] = top_ff[o];
         if (top_ff[o].pt <= cand.pt) begin
            if (o == 0) begin
               top_in[o] = cand;
            end else if (top_ff[o-1].pt > cand.pt) begin
               top_in[o] = cand;
            end else begin
               top_in[o] = top_ff[o-1];
            end
         end
      end
   end

   // list update
   always_ff @(posedge clock) begin
      for (int o = 0; o < NUM_JETS_OUT; o++) begin
         if (clear) begin
            top_ff[o] <= '0;
         end else if (cand_valid) begin
            top_ff[o] <= top_in[o];
         end
      end
   end

   assign rd_jet = top_ff[rd_idx];

endmodule

`default_nettype wire
